[rtl/smt_pkg.sv]
// shared types and constants for the sparse matrix transpose core
`default_nettype none

package smt_pkg;

    // term count registers are sized for a store of up to 63 entries
    localparam int CNT_W = 6;

    // action codes on the input channel
    localparam logic ACT_HEADER = 1'b0;
    localparam logic ACT_TERM   = 1'b1;

    typedef struct packed {
        logic [9:0]         row;
        logic [9:0]         col;
        logic signed [31:0] value;
    } term_t;

    // bump marks a term pushed out of a cell by a smaller one
    typedef struct packed {
        logic  valid;
        logic  bump;
        term_t term;
    } slot_t;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/sparse_matrix_transpose_core.sv]
// top level: sparse matrix transpose over (row, column, value) triplets
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  input   | in_valid, in_stall, action, row_index,   | in, stall out
//          | col_index, term_value                    |
//  output  | out_valid, out_stall, is_header, out_row,| out, stall in
//          | out_col, out_value, overflow, last       |
//
// term transactions load at one per cycle while in_stall is low into a chain of
// MAX_STORED_TERMS sorting cells; a term enters at the head and ripples one cell
// per cycle; once the chain has settled after the last term of a run, the header
// and then one term per cycle while out_stall is low drain from the chain head
// in_stall stays high from the last term until the final result is registered
// reset clears all control state and the cell occupancy; out_stall only delays drain
`default_nettype none

module sparse_matrix_transpose_core
    import smt_pkg::*;
#(
    parameter int MAX_STORED_TERMS = 63
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               action,
    input  wire logic [9:0]         row_index,
    input  wire logic [9:0]         col_index,
    input  wire logic signed [31:0] term_value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    is_header,
    output logic [9:0]              out_row,
    output logic [9:0]              out_col,
    output logic signed [31:0]      out_value,
    output logic                    overflow,
    output logic                    last
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_STORED_TERMS);

    typedef enum logic [2:0] {
        ST_LOAD   = 3'b001,
        ST_SETTLE = 3'b010,
        ST_DRAIN  = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [9:0]       hdr_rows_reg, hdr_rows_next;
    logic [9:0]       hdr_cols_reg, hdr_cols_next;
    logic [CNT_W-1:0] hdr_count_reg, hdr_count_next;
    logic [CNT_W-1:0] loaded_reg, loaded_next;
    logic             ovf_reg, ovf_next;
    logic             ins_valid_reg, ins_valid_next;
    term_t            ins_term_reg, ins_term_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic               is_header_reg, is_header_next;
    logic [9:0]         out_row_reg, out_row_next;
    logic [9:0]         out_col_reg, out_col_next;
    logic signed [31:0] out_value_reg, out_value_next;
    logic               overflow_reg, overflow_next;
    logic               last_reg, last_next;

    cell_ctrl_t ctrl;
    slot_t      held [MAX_STORED_TERMS];
    slot_t      pass [MAX_STORED_TERMS];
    slot_t      right_slot [MAX_STORED_TERMS];
    slot_t      feed [MAX_STORED_TERMS];

    logic             in_acc;
    logic             out_free;
    logic             busy;
    logic [CNT_W-1:0] eff_count;
    logic             eff_ovf;

    // chain of sorting cells
    genvar gi;
    generate
        for (gi = 0; gi < MAX_STORED_TERMS; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                assign feed[gi] = '{valid: ins_valid_reg, bump: 1'b0, term: ins_term_reg};
            end
            else
            begin : g_body
                assign feed[gi] = pass[gi-1];
            end
            if (gi == MAX_STORED_TERMS - 1)
            begin : g_tail
                assign right_slot[gi] = '0;
            end
            else
            begin : g_mid
                assign right_slot[gi] = held[gi+1];
            end
            smt_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (ctrl),
                .ins   (feed[gi]),
                .right (right_slot[gi]),
                .held  (held[gi]),
                .pass  (pass[gi])
            );
        end
    endgenerate

    // terms still rippling through the chain
    always_comb
    begin
        busy = ins_valid_reg;
        for (int i = 0; i < MAX_STORED_TERMS; i++)
        begin
            busy = busy | pass[i].valid;
        end
    end

    // effective term count of a header: negative means none, large saturates
    always_comb
    begin
        eff_ovf   = 1'b0;
        eff_count = term_value[CNT_W-1:0];
        if (term_value[31])
        begin
            eff_count = '0;
        end
        else if ($unsigned(term_value) > 32'(MAX_STORED_TERMS))
        begin
            eff_count = MAX_CNT;
            eff_ovf   = 1'b1;
        end
    end

    assign in_stall = (state_reg != ST_LOAD);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next      = state_reg;
        hdr_rows_next   = hdr_rows_reg;
        hdr_cols_next   = hdr_cols_reg;
        hdr_count_next  = hdr_count_reg;
        loaded_next     = loaded_reg;
        ovf_next        = ovf_reg;
        ins_valid_next  = 1'b0;
        ins_term_next   = '{row: row_index, col: col_index, value: term_value};
        out_valid_next  = out_valid_reg && out_stall;
        is_header_next  = is_header_reg;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        out_value_next  = out_value_reg;
        overflow_next   = overflow_reg;
        last_next       = last_reg;
        ctrl            = '0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (action == ACT_HEADER)
                    begin
                        // a new header abandons whatever run was pending
                        ctrl.clear     = 1'b1;
                        hdr_rows_next  = row_index;
                        hdr_cols_next  = col_index;
                        hdr_count_next = eff_count;
                        ovf_next       = eff_ovf;
                        loaded_next    = '0;
                        if (eff_count == '0)
                        begin
                            state_next = ST_SETTLE;
                        end
                    end
                    else if (loaded_reg < hdr_count_reg)
                    begin
                        // out of range columns are counted but never sorted
                        ins_valid_next = (col_index < hdr_cols_reg);
                        loaded_next    = CNT_W'(loaded_reg + 1'b1);
                        if (CNT_W'(loaded_reg + 1'b1) == hdr_count_reg)
                        begin
                            state_next = ST_SETTLE;
                        end
                    end
                end
            end
            ST_SETTLE:
            begin
                if (!busy && out_free)
                begin
                    out_valid_next = 1'b1;
                    is_header_next = 1'b1;
                    out_row_next   = hdr_cols_reg;
                    out_col_next   = hdr_rows_reg;
                    out_value_next = 32'(hdr_count_reg);
                    overflow_next  = ovf_reg;
                    last_next      = !held[0].valid;
                    state_next     = held[0].valid ? ST_DRAIN : ST_LOAD;
                end
            end
            ST_DRAIN:
            begin
                if (out_free)
                begin
                    ctrl.shift     = 1'b1;
                    out_valid_next = 1'b1;
                    is_header_next = 1'b0;
                    out_row_next   = held[0].term.col;
                    out_col_next   = held[0].term.row;
                    out_value_next = held[0].term.value;
                    overflow_next  = ovf_reg;
                    last_next      = !right_slot[0].valid;
                    if (!right_slot[0].valid)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            hdr_rows_reg  <= '0;
            hdr_cols_reg  <= '0;
            hdr_count_reg <= '0;
            loaded_reg    <= '0;
            ovf_reg       <= 1'b0;
            ins_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hdr_rows_reg  <= hdr_rows_next;
            hdr_cols_reg  <= hdr_cols_next;
            hdr_count_reg <= hdr_count_next;
            loaded_reg    <= loaded_next;
            ovf_reg       <= ovf_next;
            ins_valid_reg <= ins_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ins_term_reg  <= ins_term_next;
        is_header_reg <= is_header_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_value_reg <= out_value_next;
        overflow_reg  <= overflow_next;
        last_reg      <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign is_header = is_header_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = out_value_reg;
    assign overflow  = overflow_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

[rtl/smt_cell.sv]
// one cell of the systolic insertion sorter, holds a single term
`default_nettype none

module smt_cell
    import smt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire slot_t      ins,
    input  wire slot_t      right,
    output slot_t           held,
    output slot_t           pass
);

    logic  held_valid_reg, held_valid_next;
    term_t held_term_reg, held_term_next;
    logic  pass_valid_reg, pass_valid_next;
    logic  pass_bump_reg, pass_bump_next;
    term_t pass_term_reg, pass_term_next;

    always_comb
    begin
        held_valid_next = held_valid_reg;
        held_term_next  = held_term_reg;
        pass_valid_next = 1'b0;
        pass_bump_next  = 1'b0;
        pass_term_next  = ins.term;
        priority if (ctrl.clear)
        begin
            held_valid_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            // drain toward the head of the chain
            held_valid_next = right.valid;
            held_term_next  = right.term;
        end
        else if (ins.valid)
        begin
            // a new term passes equal columns, a displaced one takes them back,
            // so terms that share a column keep their load order
            if (!held_valid_reg || (ins.term.col < held_term_reg.col) ||
                (ins.bump && (ins.term.col == held_term_reg.col)))
            begin
                held_valid_next = 1'b1;
                held_term_next  = ins.term;
                pass_valid_next = held_valid_reg;
                pass_bump_next  = 1'b1;
                pass_term_next  = held_term_reg;
            end
            else
            begin
                pass_valid_next = 1'b1;
                pass_bump_next  = ins.bump;
                pass_term_next  = ins.term;
            end
        end
        else
        begin
            held_valid_next = held_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            pass_valid_reg <= 1'b0;
            pass_bump_reg  <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            pass_valid_reg <= pass_valid_next;
            pass_bump_reg  <= pass_bump_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_term_reg <= held_term_next;
        pass_term_reg <= pass_term_next;
    end

    assign held = '{valid: held_valid_reg, bump: 1'b0, term: held_term_reg};
    assign pass = '{valid: pass_valid_reg, bump: pass_bump_reg, term: pass_term_reg};

endmodule

`default_nettype wire

[rtl/smt_checker.sv]
// port-level checks for the sparse matrix transpose core, bound to the top level
`default_nettype none

module smt_checker
    import smt_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               action,
    input wire logic [9:0]         row_index,
    input wire logic [9:0]         col_index,
    input wire logic signed [31:0] term_value,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic               is_header,
    input wire logic [9:0]         out_row,
    input wire logic [9:0]         out_col,
    input wire logic signed [31:0] out_value,
    input wire logic               overflow,
    input wire logic               last
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(is_header) && $stable(out_row)
            && $stable(out_col) && $stable(out_value) && $stable(overflow) && $stable(last))
        else $error("stalled result changed");

    // a header with a negative count starts its one-result run at once
    a_neg_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (action == ACT_HEADER) && term_value[31] |=> in_stall)
        else $error("empty run did not start");

    // a header announcing no terms ends the run
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_header && (out_value == 32'sd0) |-> last)
        else $error("empty header without last");

    // an overflow header always carries a nonzero count
    a_ovf_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_header && overflow |-> (out_value != 32'sd0))
        else $error("overflow header with zero count");

endmodule

bind sparse_matrix_transpose_core smt_checker u_smt_checker (.*);

`default_nettype wire

[tb/sparse_matrix_transpose_core_test.sv]
// self-checking testbench for the sparse matrix transpose core
module sparse_matrix_transpose_core_test;
    import smt_pkg::*;

    localparam int STORE_DEPTH        = 63;
    localparam int RANDOM_ITEMS       = 200;
    // idling stops once this many random items have gone in
    localparam int CALM_AFTER         = 170;
    localparam int HOLD_CYCLES        = 400;
    localparam int HOLD_AFTER_RESULTS = 40;
    // long enough to cover the settle and drain of a full run
    localparam int SETTLE_CYCLES      = 200;
    localparam int CYCLE_LIMIT        = 400000;
    localparam int REPORT_LIMIT       = 10;

    // one transposed result as seen on the output channel
    typedef struct packed {
        logic               is_header;
        logic [9:0]         row;
        logic [9:0]         col;
        logic signed [31:0] value;
        logic               overflow;
        logic               last;
    } transposed_result_t;

    // keeps a shadow copy of the term store and the queue of transposed results
    class transpose_scoreboard;
        logic [9:0]         hdr_rows;
        logic [9:0]         hdr_cols;
        int                 hdr_count;
        int                 loaded_count;
        logic               overflow_flag;
        term_t              stored_terms [STORE_DEPTH];
        transposed_result_t pending_results [$];
        int                 failures;
        int                 results_checked;

        function new();
            hdr_rows        = '0;
            hdr_cols        = '0;
            hdr_count       = 0;
            loaded_count    = 0;
            overflow_flag   = 1'b0;
            failures        = 0;
            results_checked = 0;
        endfunction

        // header first, then terms in ascending original column, ties in load order
        function void emit_transpose();
            transposed_result_t res;
            res.is_header = 1'b1;
            res.row       = hdr_cols;
            res.col       = hdr_rows;
            res.value     = hdr_count;
            res.overflow  = overflow_flag;
            res.last      = 1'b1;
            pending_results.push_back(res);
            for (int col = 0; col < hdr_cols; col++)
            begin
                for (int j = 0; j < hdr_count; j++)
                begin
                    if (stored_terms[j].col == col)
                    begin
                        pending_results[pending_results.size() - 1].last = 1'b0;
                        res.is_header = 1'b0;
                        res.row       = stored_terms[j].col;
                        res.col       = stored_terms[j].row;
                        res.value     = stored_terms[j].value;
                        res.last      = 1'b1;
                        pending_results.push_back(res);
                    end
                end
            end
        endfunction

        function void predict_transpose(logic act, logic [9:0] r, logic [9:0] c,
                                        logic signed [31:0] v);
            if (act == ACT_HEADER)
            begin
                // a new header always abandons whatever run was pending
                hdr_rows      = r;
                hdr_cols      = c;
                loaded_count  = 0;
                overflow_flag = 1'b0;
                if (v < 0)
                    hdr_count = 0;
                else if (v > STORE_DEPTH)
                begin
                    hdr_count     = STORE_DEPTH;
                    overflow_flag = 1'b1;
                end
                else
                    hdr_count = v;
                if (hdr_count == 0)
                    emit_transpose();
            end
            else if (loaded_count < hdr_count)
            begin
                stored_terms[loaded_count].row   = r;
                stored_terms[loaded_count].col   = c;
                stored_terms[loaded_count].value = v;
                loaded_count++;
                if (loaded_count == hdr_count)
                    emit_transpose();
            end
        endfunction

        function void check_result(transposed_result_t got);
            transposed_result_t want;
            results_checked++;
            if (pending_results.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected result: hdr=%0b row=%0d col=%0d value=%0d %s",
                             got.is_header, got.row, got.col, got.value,
                             $sformatf("ovf=%0b last=%0b", got.overflow, got.last));
                return;
            end
            want = pending_results.pop_front();
            if (got.is_header !== want.is_header || got.row !== want.row ||
                got.col !== want.col || got.value !== want.value ||
                got.overflow !== want.overflow || got.last !== want.last)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("mismatch: expected %s, got %s",
                             $sformatf("hdr=%0b row=%0d col=%0d value=%0d ovf=%0b last=%0b",
                                       want.is_header, want.row, want.col, want.value,
                                       want.overflow, want.last),
                             $sformatf("hdr=%0b row=%0d col=%0d value=%0d ovf=%0b last=%0b",
                                       got.is_header, got.row, got.col, got.value,
                                       got.overflow, got.last));
            end
        endfunction
    endclass

    // clock, reset and block ports
    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_stall;
    logic               action     = ACT_HEADER;
    logic [9:0]         row_index  = '0;
    logic [9:0]         col_index  = '0;
    logic signed [31:0] term_value = '0;
    logic               out_valid;
    logic               out_stall  = 1'b0;
    logic               is_header;
    logic [9:0]         out_row;
    logic [9:0]         out_col;
    logic signed [31:0] out_value;
    logic               overflow;
    logic               last;

    // run control shared by the sender and the receiver
    transpose_scoreboard sb = new();
    bit calm          = 1'b0;
    bit held_off      = 1'b0;
    int send_gap_pct  = 0;
    int stall_pct     = 0;
    int items_sent    = 0;
    int random_items  = 0;
    int cycle_count   = 0;

    sparse_matrix_transpose_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .row_index  (row_index),
        .col_index  (col_index),
        .term_value (term_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .is_header  (is_header),
        .out_row    (out_row),
        .out_col    (out_col),
        .out_value  (out_value),
        .overflow   (overflow),
        .last       (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // both channels are sampled at the rising edge; inputs are predicted before
    // outputs are checked, though no result can leave in the cycle its cause arrives
    always @(posedge clk)
    begin
        transposed_result_t seen;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.predict_transpose(action, row_index, col_index, term_value);
            if (out_valid && !out_stall)
            begin
                seen.is_header = is_header;
                seen.row       = out_row;
                seen.col       = out_col;
                seen.value     = out_value;
                seen.overflow  = overflow;
                seen.last      = last;
                sb.check_result(seen);
            end
        end
    end

    // idle density for the next stretch: none, light or heavy
    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 10;
            default: return 35;
        endcase
    endfunction

    // column counts mostly small so that terms share columns
    function automatic logic [9:0] pick_cols();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return 10'($urandom_range(1, 8));
        if (pick < 9)
            return 10'($urandom_range(1, 64));
        return 10'($urandom_range(0, 1023));
    endfunction

    // receiver: random stall bursts, plus one long hold-off that backs the
    // block up until it stops taking transactions on its input
    initial
    begin
        int burst;
        int stretch;
        stretch = 0;
        forever
        begin
            @(negedge clk);
            if (stretch == 0)
            begin
                stall_pct = pick_pct();
                stretch   = 48;
            end
            stretch--;
            if (rst_n && !held_off && sb.results_checked >= HOLD_AFTER_RESULTS)
            begin
                held_off  = 1'b1;
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall = 1'b0;
            end
            else if (rst_n && !calm && $urandom_range(0, 99) < stall_pct)
            begin
                burst     = $urandom_range(1, 17);
                out_stall = 1'b1;
                repeat (burst) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    // drive one transaction at the falling edge and hold it until accepted
    task automatic send_item(logic act, logic [9:0] r, logic [9:0] c,
                             logic signed [31:0] v);
        int gap;
        if (!calm && $urandom_range(0, 99) < send_gap_pct)
        begin
            gap = $urandom_range(1, 17);
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid   = 1'b1;
        action     = act;
        row_index  = r;
        col_index  = c;
        term_value = v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (items_sent % 16 == 0)
            send_gap_pct = pick_pct();
    endtask

    // header plus its terms; columns either mostly in range or all out of range
    task automatic send_run(logic signed [31:0] count_field, int n_terms,
                            logic [9:0] n_cols, bit none_qualify);
        logic [9:0] c;
        send_item(ACT_HEADER, 10'($urandom_range(0, 1023)), n_cols, count_field);
        for (int k = 0; k < n_terms; k++)
        begin
            if (none_qualify)
                c = 10'($urandom_range(n_cols, 1023));
            else if ($urandom_range(0, 9) == 0)
                c = 10'($urandom_range(0, 1023));
            else
                c = 10'($urandom_range(0, n_cols));
            send_item(ACT_TERM, 10'($urandom_range(0, 1023)), c, $urandom);
        end
        random_items += 1 + n_terms;
    endtask

    initial
    begin
        int choice;
        int n;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // empty matrix, and negative counts that collapse to zero terms
        send_item(ACT_HEADER, 10'd0, 10'd0, 32'sd0);
        send_item(ACT_HEADER, 10'd1023, 10'd1023, -32'sd1);
        send_item(ACT_HEADER, 10'd5, 10'd7, 32'sh80000000);
        // term with no run open is dropped
        send_item(ACT_TERM, 10'd1023, 10'd1023, 32'sh7fffffff);
        // run cut short by a new header
        send_item(ACT_HEADER, 10'd4, 10'd4, 32'sd3);
        send_item(ACT_TERM, 10'd1, 10'd2, 32'sh7fffffff);
        // widest matrix; column 1023 falls outside, two terms share column zero
        send_item(ACT_HEADER, 10'd1023, 10'd1023, 32'sd4);
        send_item(ACT_TERM, 10'd1023, 10'd1023, 32'sh80000000);
        send_item(ACT_TERM, 10'd0, 10'd0, -32'sd1);
        send_item(ACT_TERM, 10'd1023, 10'd0, 32'sh7fffffff);
        send_item(ACT_TERM, 10'd5, 10'd1022, 32'sh80000000);
        // no term qualifies, so only the header comes out
        send_item(ACT_HEADER, 10'd3, 10'd2, 32'sd2);
        send_item(ACT_TERM, 10'd0, 10'd2, 32'sd11);
        send_item(ACT_TERM, 10'd1, 10'd5, 32'sd12);
        // reverse column order forces a full reorder
        send_item(ACT_HEADER, 10'd2, 10'd3, 32'sd3);
        send_item(ACT_TERM, 10'd0, 10'd2, 32'sd10);
        send_item(ACT_TERM, 10'd1, 10'd1, -32'sd20);
        send_item(ACT_TERM, 10'd1, 10'd0, 32'sd30);
        // single term
        send_item(ACT_HEADER, 10'd1, 10'd1, 32'sd1);
        send_item(ACT_TERM, 10'd0, 10'd0, 32'sd1);

        // one saturating run up front so the full store and the flag are seen
        send_run($urandom_range(STORE_DEPTH + 1, 32'h7fffffff), STORE_DEPTH, pick_cols(), 1'b0);

        while (random_items < RANDOM_ITEMS)
        begin
            if (random_items >= CALM_AFTER)
                calm = 1'b1;
            choice = $urandom_range(0, 99);
            if (choice < 62)
            begin
                n = $urandom_range(1, 8);
                send_run(n, n, pick_cols(), 1'b0);
            end
            else if (choice < 70)
            begin
                // zero or negative count
                if ($urandom_range(0, 1) == 1)
                    send_run(32'sd0, 0, 10'($urandom_range(0, 1023)), 1'b0);
                else
                    send_run($urandom | 32'h80000000, 0, 10'($urandom_range(0, 1023)), 1'b0);
            end
            else if (choice < 78)
            begin
                // partial run, then a complete one that abandons it
                n = $urandom_range(2, 8);
                send_run(n, $urandom_range(0, n - 1), pick_cols(), 1'b0);
                n = $urandom_range(1, 8);
                send_run(n, n, pick_cols(), 1'b0);
            end
            else if (choice < 84)
            begin
                // stray terms after a finished run; these do not count
                repeat ($urandom_range(1, 3))
                    send_item(ACT_TERM, 10'($urandom_range(0, 1023)),
                              10'($urandom_range(0, 1023)), $urandom);
            end
            else if (choice < 92)
            begin
                n = $urandom_range(1, 6);
                send_run(n, n, 10'($urandom_range(0, 1023)), 1'b1);
            end
            else if (choice < 95)
            begin
                // full store, either exactly at depth or saturating
                if ($urandom_range(0, 1) == 1)
                    send_run(STORE_DEPTH, STORE_DEPTH, pick_cols(), 1'b0);
                else
                    send_run($urandom_range(STORE_DEPTH + 1, 32'h7fffffff), STORE_DEPTH,
                             pick_cols(), 1'b0);
            end
            else
            begin
                n = $urandom_range(1, 4);
                send_run(n, n, 10'd1023, 1'b0);
            end
        end

        @(negedge clk);
        in_valid = 1'b0;

        // drain, then give the block time to show any stray output
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
